FILE: rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

	typedef logic [3:0] code_t;

	localparam code_t CodeLeft   = 4'd1;
	localparam code_t CodeRight  = 4'd2;
	localparam code_t CodeBottom = 4'd4;
	localparam code_t CodeTop    = 4'd8;

	localparam logic [1:0] RegLeft   = 2'd0;
	localparam logic [1:0] RegRight  = 2'd1;
	localparam logic [1:0] RegBottom = 2'd2;
	localparam logic [1:0] RegTop    = 2'd3;

	// widest coordinate the outcode helper takes
	localparam int CoordMax = 32;

	function automatic code_t outcode(
		input logic signed [CoordMax-1:0] x,
		input logic signed [CoordMax-1:0] y,
		input logic signed [CoordMax-1:0] wl,
		input logic signed [CoordMax-1:0] wr,
		input logic signed [CoordMax-1:0] wb,
		input logic signed [CoordMax-1:0] wt
	);
		code_t c;
		c = '0;
		if (x < wl) c = c | CodeLeft;
		else if (x > wr) c = c | CodeRight;
		if (y < wb) c = c | CodeBottom;
		else if (y > wt) c = c | CodeTop;
		return c;
	endfunction

endpackage

FILE: rtl/line_segment_clipper_top.sv
`timescale 1ns / 1ps

// Cohen-Sutherland clipper: one segment per beat against the window in four
// registers, with one segment accepted every cycle while the output is taken.
// The pipeline is an input register, MAX_CLIP_STEPS unrolled clip steps, each
// holding a restoring divider that makes one quotient bit per stage, and an
// output register. A stall on the output freezes the whole pipeline.
// Rejected segments come out with all coordinates zero.

module line_segment_clipper_top import lsc_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int MAX_CLIP_STEPS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_idx,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// start_x, start_y, end_x, end_y
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// accepted, clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
	output logic [((4*COORD_WIDTH+8)/8)*8-1:0] m_tdata
);

	localparam int W    = COORD_WIDTH;
	localparam int SegW = 2 + 4 * W + 8;
	localparam int OutW = ((4 * W + 8) / 8) * 8;

	typedef struct packed {
		logic                done;
		logic                acc;
		logic signed [W-1:0] x0;
		logic signed [W-1:0] y0;
		logic signed [W-1:0] x1;
		logic signed [W-1:0] y1;
		code_t               c0;
		code_t               c1;
	} seg_t;

	logic signed [W-1:0] win_left_q, win_right_q, win_bottom_q, win_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q <= W'(10);
			win_right_q <= W'(200);
			win_bottom_q <= W'(10);
			win_top_q <= W'(200);
		end else if (cfg_we) begin
			case (cfg_idx)
				RegLeft:   win_left_q <= cfg_data;
				RegRight:  win_right_q <= cfg_data;
				RegBottom: win_bottom_q <= cfg_data;
				RegTop:    win_top_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic signed [W-1:0] ix0, iy0, ix1, iy1;
	assign ix0 = s_tdata[W-1:0];
	assign iy0 = s_tdata[2*W-1:W];
	assign ix1 = s_tdata[3*W-1:2*W];
	assign iy1 = s_tdata[4*W-1:3*W];

	logic vld_s1;
	seg_t seg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1.done <= 1'b0;
			seg_s1.acc <= 1'b0;
			seg_s1.x0 <= ix0;
			seg_s1.y0 <= iy0;
			seg_s1.x1 <= ix1;
			seg_s1.y1 <= iy1;
			seg_s1.c0 <= outcode(CoordMax'(ix0), CoordMax'(iy0), CoordMax'(win_left_q),
				CoordMax'(win_right_q), CoordMax'(win_bottom_q), CoordMax'(win_top_q));
			seg_s1.c1 <= outcode(CoordMax'(ix1), CoordMax'(iy1), CoordMax'(win_left_q),
				CoordMax'(win_right_q), CoordMax'(win_bottom_q), CoordMax'(win_top_q));
		end
	end

	logic            vld_c [0:MAX_CLIP_STEPS];
	logic [SegW-1:0] seg_c [0:MAX_CLIP_STEPS];

	assign vld_c[0] = vld_s1;
	assign seg_c[0] = SegW'(seg_s1);

	for (genvar i = 0; i < MAX_CLIP_STEPS; i++) begin : g_step
		lsc_clip_stage #(.W(W), .SegW(SegW)) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.in_vld     (vld_c[i]),
			.in_seg     (seg_c[i]),
			.win_left   (win_left_q),
			.win_right  (win_right_q),
			.win_bottom (win_bottom_q),
			.win_top    (win_top_q),
			.out_vld    (vld_c[i+1]),
			.out_seg    (seg_c[i+1])
		);
	end

	// still open after the last step: accept only if both ends landed inside
	seg_t sl;
	logic acc_f;
	assign sl = seg_t'(seg_c[MAX_CLIP_STEPS]);
	assign acc_f = sl.done ? sl.acc : ((sl.c0 == '0) && (sl.c1 == '0));

	logic            out_vld_q;
	logic [OutW-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= vld_c[MAX_CLIP_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc_f) out_data_q <= OutW'({sl.y1, sl.x1, sl.y0, sl.x0, 1'b1});
			else out_data_q <= '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;

	logic signed [W-1:0] osx, osy, oex, oey;
	assign osx = m_tdata[W:1];
	assign osy = m_tdata[2*W:W+1];
	assign oex = m_tdata[3*W:2*W+1];
	assign oey = m_tdata[4*W:3*W+1];

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata == '0))
		else $error("rejected beat carries nonzero coordinates");

	a_acc_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (osx >= win_left_q && osx <= win_right_q &&
		oex >= win_left_q && oex <= win_right_q && osy >= win_bottom_q &&
		osy <= win_top_q && oey >= win_bottom_q && oey <= win_top_q))
		else $error("accepted endpoint outside window");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

endmodule

FILE: rtl/lsc_clip_stage.sv
`timescale 1ns / 1ps

module lsc_clip_stage import lsc_pkg::*; #(
	parameter int W = 16,
	parameter int SegW = 2 + 4 * W + 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic [SegW-1:0]     in_seg,
	input  logic signed [W-1:0] win_left,
	input  logic signed [W-1:0] win_right,
	input  logic signed [W-1:0] win_bottom,
	input  logic signed [W-1:0] win_top,
	output logic                out_vld,
	output logic [SegW-1:0]     out_seg
);

	localparam int W1 = W + 1;
	localparam int Q  = W + 2;
	localparam int PW = 2 * W + 2;

	typedef struct packed {
		logic                done;
		logic                acc;
		logic signed [W-1:0] x0;
		logic signed [W-1:0] y0;
		logic signed [W-1:0] x1;
		logic signed [W-1:0] y1;
		code_t               c0;
		code_t               c1;
	} seg_t;

	typedef struct packed {
		logic                active;
		logic                upd0;
		logic                axis_y;
		logic                neg;
		logic                zero_c;
		logic signed [W-1:0] edge_v;
		logic signed [W-1:0] base;
	} ctl_t;

	seg_t si;
	assign si = seg_t'(in_seg);

	// setup: pick the edge and form the three differences
	seg_t                 seg_a;
	ctl_t                 ctl_a;
	logic signed [W1-1:0] da, db, dc, dx, dy;
	logic [W1-1:0]        ma, mb, mc;
	code_t                co;
	logic                 both_in, rej;

	always_comb begin
		seg_a = si;
		ctl_a = '0;
		both_in = (si.c0 == '0) && (si.c1 == '0);
		rej = (si.c0 & si.c1) != '0;
		co = (si.c0 != '0) ? si.c0 : si.c1;
		dx = W1'(si.x1) - W1'(si.x0);
		dy = W1'(si.y1) - W1'(si.y0);
		if ((co & CodeTop) != '0) begin
			da = dx; db = W1'(win_top) - W1'(si.y0); dc = dy;
			ctl_a.edge_v = win_top; ctl_a.axis_y = 1'b1; ctl_a.base = si.x0;
		end else if ((co & CodeBottom) != '0) begin
			da = dx; db = W1'(win_bottom) - W1'(si.y0); dc = dy;
			ctl_a.edge_v = win_bottom; ctl_a.axis_y = 1'b1; ctl_a.base = si.x0;
		end else if ((co & CodeRight) != '0) begin
			da = dy; db = W1'(win_right) - W1'(si.x0); dc = dx;
			ctl_a.edge_v = win_right; ctl_a.axis_y = 1'b0; ctl_a.base = si.y0;
		end else begin
			da = dy; db = W1'(win_left) - W1'(si.x0); dc = dx;
			ctl_a.edge_v = win_left; ctl_a.axis_y = 1'b0; ctl_a.base = si.y0;
		end
		ctl_a.upd0 = si.c0 != '0;
		ctl_a.neg = da[W] ^ db[W] ^ dc[W];
		ctl_a.zero_c = dc == '0;
		ctl_a.active = !si.done && !both_in && !rej;
		if (!si.done) begin
			if (both_in) begin
				seg_a.done = 1'b1;
				seg_a.acc = 1'b1;
			end else if (rej) begin
				seg_a.done = 1'b1;
				seg_a.acc = 1'b0;
			end
		end
		ma = da[W] ? W1'(-da) : W1'(da);
		mb = db[W] ? W1'(-db) : W1'(db);
		mc = dc[W] ? W1'(-dc) : W1'(dc);
	end

	logic          vld_s1;
	seg_t          seg_s1;
	ctl_t          ctl_s1;
	logic [W1-1:0] ma_s1, mb_s1, mc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= seg_a;
			ctl_s1 <= ctl_a;
			ma_s1 <= ma;
			mb_s1 <= mb;
			mc_s1 <= mc;
		end
	end

	// exact product of magnitudes
	logic          vld_s2;
	seg_t          seg_s2;
	ctl_t          ctl_s2;
	logic [PW-1:0] prod_s2;
	logic [W1-1:0] mc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s2 <= seg_s1;
			ctl_s2 <= ctl_s1;
			prod_s2 <= PW'(ma_s1) * PW'(mb_s1);
			mc_s2 <= mc_s1;
		end
	end

	// restoring divider, one quotient bit per stage
	logic          vld_s3 [1:Q];
	logic [W:0]    rem_s3 [1:Q];
	logic [Q-1:0]  pq_s3  [1:Q];
	logic [W1-1:0] dv_s3  [1:Q];
	ctl_t          ctl_s3 [1:Q];
	seg_t          seg_s3 [1:Q];

	for (genvar k = 0; k < Q; k++) begin : g_div
		logic          src_vld;
		logic [W:0]    src_rem;
		logic [Q-1:0]  src_pq;
		logic [W1-1:0] src_dv;
		ctl_t          src_ctl;
		seg_t          src_seg;
		logic [W1:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign src_vld = vld_s2;
			assign src_rem = W1'(prod_s2[PW-1:Q]);
			assign src_pq  = prod_s2[Q-1:0];
			assign src_dv  = mc_s2;
			assign src_ctl = ctl_s2;
			assign src_seg = seg_s2;
		end else begin : g_next
			assign src_vld = vld_s3[k];
			assign src_rem = rem_s3[k];
			assign src_pq  = pq_s3[k];
			assign src_dv  = dv_s3[k];
			assign src_ctl = ctl_s3[k];
			assign src_seg = seg_s3[k];
		end

		assign t  = {src_rem, src_pq[Q-1]};
		assign ge = t >= {1'b0, src_dv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s3[k+1] <= 1'b0;
			else if (adv) vld_s3[k+1] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s3[k+1] <= ge ? W1'(t - {1'b0, src_dv}) : W1'(t);
				pq_s3[k+1]  <= {src_pq[Q-2:0], ge};
				dv_s3[k+1]  <= src_dv;
				ctl_s3[k+1] <= src_ctl;
				seg_s3[k+1] <= src_seg;
			end
		end
	end

	// apply sign, move the endpoint and recode it
	ctl_t                  ctl_f;
	seg_t                  seg_f;
	logic signed [W+2:0]   qs, sum;
	logic signed [W-1:0]   nx, ny, nv;

	always_comb begin
		ctl_f = ctl_s3[Q];
		seg_f = seg_s3[Q];
		if (ctl_f.zero_c) qs = '0;
		else if (ctl_f.neg) qs = -$signed({1'b0, pq_s3[Q]});
		else qs = $signed({1'b0, pq_s3[Q]});
		sum = (W+3)'(ctl_f.base) + qs;
		nv = sum[W-1:0];
		nx = ctl_f.axis_y ? nv : ctl_f.edge_v;
		ny = ctl_f.axis_y ? ctl_f.edge_v : nv;
		if (ctl_f.active) begin
			if (ctl_f.upd0) begin
				seg_f.x0 = nx;
				seg_f.y0 = ny;
				seg_f.c0 = outcode(CoordMax'(nx), CoordMax'(ny), CoordMax'(win_left),
					CoordMax'(win_right), CoordMax'(win_bottom), CoordMax'(win_top));
			end else begin
				seg_f.x1 = nx;
				seg_f.y1 = ny;
				seg_f.c1 = outcode(CoordMax'(nx), CoordMax'(ny), CoordMax'(win_left),
					CoordMax'(win_right), CoordMax'(win_bottom), CoordMax'(win_top));
			end
		end
	end

	logic vld_s4;
	seg_t seg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3[Q];
	end

	always_ff @(posedge clk) begin
		if (adv) seg_s4 <= seg_f;
	end

	assign out_vld = vld_s4;
	assign out_seg = SegW'(seg_s4);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lsc_pkg::*;

	localparam int W = 16;
	localparam int LATENCY = 86;
	localparam longint CYCLE_LIMIT = 1200000;

	typedef struct packed {
		logic signed [W-1:0] ey;
		logic signed [W-1:0] ex;
		logic signed [W-1:0] sy;
		logic signed [W-1:0] sx;
	} segment_t;

	typedef struct packed {
		logic [6:0]          pad;
		logic signed [W-1:0] ey;
		logic signed [W-1:0] ex;
		logic signed [W-1:0] sy;
		logic signed [W-1:0] sx;
		logic                ok;
	} clip_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = '0;
	logic [W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	// start_x, start_y, end_x, end_y
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	// accepted, clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
	logic [71:0] m_tdata;

	line_segment_clipper_top u_top (.*);

	longint win_l = 10, win_r = 200, win_b = 10, win_t = 200;
	segment_t pending_segs[$];
	clip_t expected_clips[$];
	int send_idle = 0, recv_idle = 0;
	bit hold_send = 0;
	int errors = 0;
	longint cycles = 0;

	initial forever #10 clk = ~clk;

	function automatic code_t region(longint x, longint y);
		code_t c = '0;
		if (x < win_l) c |= CodeLeft;
		else if (x > win_r) c |= CodeRight;
		if (y < win_b) c |= CodeBottom;
		else if (y > win_t) c |= CodeTop;
		return c;
	endfunction

	// product is exact in 64 bits for 17-bit operands; sv division truncates toward zero
	function automatic longint scaled(longint a, longint b, longint c);
		if (c == 0) return 0;
		return (a * b) / c;
	endfunction

	function automatic clip_t clip_segment(segment_t s);
		clip_t r;
		longint x0, y0, x1, y1, nx, ny;
		code_t c0, c1, co;
		int steps;
		x0 = longint'(s.sx); y0 = longint'(s.sy);
		x1 = longint'(s.ex); y1 = longint'(s.ey);
		c0 = region(x0, y0); c1 = region(x1, y1);
		steps = 0;
		r = '0;
		forever begin
			if (c0 == 0 && c1 == 0) begin
				r.ok = 1'b1;
				r.sx = W'(x0); r.sy = W'(y0); r.ex = W'(x1); r.ey = W'(y1);
				break;
			end
			if ((c0 & c1) != 0 || steps >= 4) break;
			steps++;
			co = (c0 != 0) ? c0 : c1;
			if (co & CodeTop) begin
				nx = x0 + scaled(x1 - x0, win_t - y0, y1 - y0); ny = win_t;
			end else if (co & CodeBottom) begin
				nx = x0 + scaled(x1 - x0, win_b - y0, y1 - y0); ny = win_b;
			end else if (co & CodeRight) begin
				ny = y0 + scaled(y1 - y0, win_r - x0, x1 - x0); nx = win_r;
			end else begin
				ny = y0 + scaled(y1 - y0, win_l - x0, x1 - x0); nx = win_l;
			end
			if (c0 != 0) begin
				x0 = nx; y0 = ny; c0 = region(x0, y0);
			end else begin
				x1 = nx; y1 = ny; c1 = region(x1, y1);
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_clips.push_back(clip_segment(segment_t'(s_tdata)));
		end
		if (!s_tvalid || s_tready) begin
			if (pending_segs.size() > 0 && !hold_send &&
					$urandom_range(99) >= send_idle) begin
				s_tdata <= pending_segs.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		clip_t got, want;
		cycles++;
		if (m_tvalid && m_tready) begin
			got = clip_t'(m_tdata);
			if (expected_clips.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat %h", m_tdata);
			end else begin
				want = expected_clips.pop_front();
				if (got.ok !== want.ok || got.sx !== want.sx || got.sy !== want.sy ||
						got.ex !== want.ex || got.ey !== want.ey) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp ok=%0d (%0d,%0d)-(%0d,%0d) got ok=%0d (%0d,%0d)-(%0d,%0d)",
							want.ok, want.sx, want.sy, want.ex, want.ey,
							got.ok, got.sx, got.sy, got.ex, got.ey);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [W-1:0] rand_coord(longint lo, longint hi);
		case ($urandom_range(3))
			0: return W'($urandom());
			default: return W'(lo - 40 + longint'($urandom_range(int'(hi - lo + 80))));
		endcase
	endfunction

	function automatic segment_t rand_seg();
		segment_t s;
		s.sx = rand_coord(win_l, win_r);
		s.sy = rand_coord(win_b, win_t);
		s.ex = rand_coord(win_l, win_r);
		s.ey = rand_coord(win_b, win_t);
		return s;
	endfunction

	task automatic drain();
		while (pending_segs.size() > 0 || s_tvalid || expected_clips.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_window(longint l, longint r, longint b, longint t);
		longint vals[4];
		vals = '{l, r, b, t};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= i[1:0];
			cfg_data <= W'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		win_l = l; win_r = r; win_b = b; win_t = t;
	endtask

	function automatic segment_t seg(longint a, longint b, longint c, longint d);
		segment_t s;
		s.sx = W'(a); s.sy = W'(b); s.ex = W'(c); s.ey = W'(d);
		return s;
	endfunction

	task automatic phase(int n);
		for (int i = 0; i < n; i++) pending_segs.push_back(rand_seg());
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset window, directed: inside, trivial reject, crossings, extremes
		pending_segs.push_back(seg(50, 50, 150, 150));
		pending_segs.push_back(seg(0, 0, 5, 5));
		pending_segs.push_back(seg(0, 100, 300, 100));
		pending_segs.push_back(seg(100, -50, 100, 400));
		pending_segs.push_back(seg(-32768, -32768, 32767, 32767));
		pending_segs.push_back(seg(32767, -32768, -32768, 32767));
		pending_segs.push_back(seg(-32768, 32767, -32768, 32767));
		pending_segs.push_back(seg(0, 150, 150, 300));
		pending_segs.push_back(seg(10, 10, 200, 200));
		pending_segs.push_back(seg(9, 201, 201, 9));
		pending_segs.push_back(seg(-5, 0, 0, 215));
		pending_segs.push_back(seg(250, 50, 50, 250));
		pending_segs.push_back(seg(-1, -1, -1, -1));
		drain();
		set_window(-32768, 32767, -32768, 32767);
		pending_segs.push_back(seg(-32768, -32768, 32767, 32767));
		pending_segs.push_back(seg(32767, 0, -32768, 0));
		drain();
		// inverted window rejects everything
		set_window(100, -100, 100, -100);
		pending_segs.push_back(seg(0, 0, 50, 50));
		pending_segs.push_back(seg(-200, -200, 200, 200));
		drain();
		set_window(-1000, 1000, -500, 500);
		send_idle = 31; recv_idle = 87;
		phase(300);
		set_window(-32768, 32767, -20, 20);
		send_idle = 87; recv_idle = 31;
		phase(300);
		set_window(32767, 32767, -32768, -32768);
		phase(100);
		set_window(10, 200, 10, 200);
		send_idle = 0; recv_idle = 0;
		for (int i = 0; i < 500; i++) pending_segs.push_back(rand_seg());
		// sender holds off until the pipeline has emptied
		while (pending_segs.size() > 250) @(posedge clk);
		hold_send = 1;
		while (s_tvalid || expected_clips.size() > 0) @(posedge clk);
		hold_send = 0;
		drain();
		set_window(-300, 300, -2000, 2000);
		phase(500);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
rtl/lsc_pkg.sv
rtl/lsc_clip_stage.sv
rtl/line_segment_clipper_top.sv
verif/testbench.sv
